>>> src/float_to_decimal_text_macros.svh
// assertion helpers used by the rtl top level
`ifndef FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`define FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`ifndef SYNTHESIS
`define F2DT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define F2DT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define F2DT_ASSERT(label, clk, rst_n, prop, msg)
`define F2DT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> src/f2dt_pkg.sv
package f2dt_pkg;
    localparam int FRACTION_DIGITS_DEF = 6;
    localparam int NUM_DIGITS = 20;
    localparam int MAG_W = 64;
    localparam int PTR_W = $clog2(NUM_DIGITS);
    localparam int CNT_W = $clog2(MAG_W);

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_POINT = 7'h2E;

    typedef logic [3:0] t_digit;
    typedef enum logic [1:0] {K_SIGN, K_DIGIT, K_DOT} t_kind;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  norm;
        logic  dabble;
        logic  find;
        logic  emit;
        t_kind kind;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic ptr_at_fd;
        logic ptr_zero;
    } t_stat;

    function automatic logic [63:0] scale_pow(input int fd);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < fd; k++) p = p * 64'd10;
        return p;
    endfunction

    function automatic int scale_msb(input int fd);
        logic [63:0] p;
        int m;
        p = scale_pow(fd);
        m = 0;
        for (int k = 0; k < 64; k++) if (p[k]) m = k;
        return m;
    endfunction

    // 24-bit significand of the scale, leading one at bit 23
    function automatic logic [23:0] scale_mant(input int fd);
        logic [63:0] p;
        int m;
        p = scale_pow(fd);
        m = scale_msb(fd);
        if (m >= 23) return 24'(p >> (m - 23));
        else return 24'(p << (23 - m));
    endfunction
endpackage

>>> src/f2dt_datapath.sv
module f2dt_datapath #(
    parameter int FRACTION_DIGITS = f2dt_pkg::FRACTION_DIGITS_DEF
) (
    input  logic           i_clk,
    input  f2dt_pkg::t_cmd i_cmd,
    input  logic [31:0]    i_float_bits,
    output f2dt_pkg::t_stat o_stat,
    output logic [6:0]     o_char,
    output logic           o_last,
    output logic           o_err
);
    import f2dt_pkg::*;

    localparam logic [23:0] MS = scale_mant(FRACTION_DIGITS);
    localparam int FB = scale_msb(FRACTION_DIGITS) - 150;

    logic [31:0]      r_bits;
    logic [47:0]      r_prod;
    logic [7:0]       r_exp;
    logic             r_frac_nz;
    logic             r_sign;
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    logic             r_err;
    logic [CNT_W-1:0] r_cnt;
    t_digit           r_bcd [NUM_DIGITS];
    logic [PTR_W-1:0] r_ptr;
    logic [6:0]       r_char;
    logic             r_last;
    logic             r_oerr;

    // rounding of the product and truncation to an integer
    logic             hi, guard, sticky, rnd;
    logic [23:0]      r24;
    logic [24:0]      rm;
    logic signed [10:0] f;
    logic [10:0]      shr;
    logic [64:0]      y;
    logic             big, is_nan, is_inf, is_zero, ovf;
    logic [MAG_W-1:0] n_mag;
    t_digit           adj [NUM_DIGITS];
    logic [PTR_W-1:0] lead;
    t_digit           dsel;

    always_comb begin
        hi     = r_prod[47];
        r24    = hi ? r_prod[47:24] : r_prod[46:23];
        guard  = hi ? r_prod[23] : r_prod[22];
        sticky = (|r_prod[21:0]) | (hi & r_prod[22]);
        rnd    = guard & (sticky | r24[0]);
        rm     = {1'b0, r24} + {24'd0, rnd};
        f      = $signed({3'b000, r_exp}) + $signed(11'(FB)) + $signed({10'd0, hi});
        shr    = 11'(-f);
        big    = 1'b0;
        y      = '0;
        if (f < 0) begin
            if (shr < 11'd25) y = {40'd0, rm} >> shr[4:0];
        end else if (f > 11'sd40) begin
            big = 1'b1;
        end else begin
            y = {40'd0, rm} << f[5:0];
        end
        is_nan  = (r_exp == 8'hFF) && r_frac_nz;
        is_inf  = (r_exp == 8'hFF) && !r_frac_nz;
        is_zero = (r_exp == 8'h00);
        ovf     = !is_nan && (is_inf || big ||
                  (r_sign ? (y > {2'b01, 63'd0}) : (y[64] | y[63])));
        if (is_nan || is_zero) n_mag = '0;
        else if (ovf) n_mag = r_sign ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else n_mag = y[63:0];
    end

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++)
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        lead = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
            if (r_bcd[i] != 4'd0) lead = PTR_W'(i);
        if (lead < PTR_W'(FRACTION_DIGITS)) lead = PTR_W'(FRACTION_DIGITS);
        dsel = r_bcd[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_bits <= i_float_bits;
        if (i_cmd.mul) begin
            r_prod    <= {1'b1, r_bits[22:0]} * MS;
            r_exp     <= r_bits[30:23];
            r_frac_nz <= |r_bits[22:0];
            r_sign    <= r_bits[31];
        end
        if (i_cmd.norm) begin
            r_mag <= n_mag;
            r_neg <= r_sign && (n_mag != '0);
            r_err <= is_nan || ovf;
            r_cnt <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) r_bcd[i] <= 4'd0;
        end
        if (i_cmd.dabble) begin
            r_mag    <= {r_mag[MAG_W-2:0], 1'b0};
            r_cnt    <= r_cnt + 1'b1;
            r_bcd[0] <= {adj[0][2:0], r_mag[MAG_W-1]};
            for (int i = 1; i < NUM_DIGITS; i++) r_bcd[i] <= {adj[i][2:0], adj[i-1][3]};
        end
        if (i_cmd.find) r_ptr <= lead;
        if (i_cmd.emit) begin
            r_last <= i_cmd.last;
            r_oerr <= r_err;
            case (i_cmd.kind)
                K_SIGN:  r_char <= CH_MINUS;
                K_DOT:   r_char <= CH_POINT;
                K_DIGIT: begin
                    r_char <= CH_ZERO | {3'd0, dsel};
                    r_ptr  <= r_ptr - 1'b1;
                end
                default: r_char <= CH_POINT;
            endcase
        end
    end

    assign o_stat.conv_done = (r_cnt == {CNT_W{1'b1}});
    assign o_stat.neg       = r_neg;
    assign o_stat.ptr_at_fd = (r_ptr == PTR_W'(FRACTION_DIGITS));
    assign o_stat.ptr_zero  = (r_ptr == '0);
    assign o_char = r_char;
    assign o_last = r_last;
    assign o_err  = r_oerr;
endmodule

>>> src/f2dt_ctrl.sv
module f2dt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_m_tready,
    input  f2dt_pkg::t_stat i_stat,
    output f2dt_pkg::t_cmd  o_cmd,
    output logic            o_s_tready,
    output logic            o_m_tvalid
);
    import f2dt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_NORM, S_CONV, S_FIND, S_SIGN, S_INT, S_DOT, S_FRAC
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    always_comb begin
        out_free = !r_valid || i_m_tready;
        o_cmd    = '0;
        o_cmd.kind = K_DIGIT;
        n_state  = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_state = S_CONV;
            end
            S_CONV: begin
                o_cmd.dabble = 1'b1;
                if (i_stat.conv_done) n_state = S_FIND;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state = S_SIGN;
            end
            S_SIGN: begin
                if (!i_stat.neg) begin
                    n_state = S_INT;
                end else if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_SIGN;
                    n_state = S_INT;
                end
            end
            S_INT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.ptr_at_fd) n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_DOT;
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_stat.ptr_zero;
                    if (i_stat.ptr_zero) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_valid = o_cmd.emit ? 1'b1 : (i_m_tready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_valid;
endmodule

>>> src/float_to_decimal_text.sv
// float_to_decimal_text: takes one ieee single-precision bit pattern per item, scales it by
// 10^FRACTION_DIGITS with single-precision round to nearest even, truncates toward zero to a
// signed 64-bit integer and streams the decimal text one character per output item: an
// optional '-', the integer digits (at least one), '.', then FRACTION_DIGITS digits, tlast
// on the final character. saturated products and nan raise tuser on every character of that
// text. one item is handled at a time, in order: taking it, the 24x24 significand multiply,
// rounding and the integer shift, binary-to-bcd conversion (one magnitude bit per cycle),
// locating the leading digit, then the characters one at a time, each as soon as the output
// register is free, with the sign slot passed over when there is no minus. a text holds 8 to
// 21 characters. the last character sits in the output register while the next item is
// already accepted.
module float_to_decimal_text #(
    parameter int FRACTION_DIGITS = f2dt_pkg::FRACTION_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] float_bits
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] char_code, [7] zero
    output logic        o_m_tlast,   // last_char
    output logic        o_m_tuser    // range_error
);
    import f2dt_pkg::*;
`include "float_to_decimal_text_macros.svh"

    t_cmd       cmd;
    t_stat      stat;
    logic [6:0] char_code;

    // sequencer: walks load, multiply, normalize, conversion, leading-digit search and character emission
    f2dt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    // arithmetic, bcd digit store and the output character register
    f2dt_datapath #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_float_bits (i_s_tdata),
        .o_stat       (stat),
        .o_char       (char_code),
        .o_last       (o_m_tlast),
        .o_err        (o_m_tuser)
    );

    assign o_m_tdata = {1'b0, char_code};

    // a taken item closes the input until its text is done
    `F2DT_ASSERT(a_accept_closes, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "input still open after accept")
    // a character is only written into a free or draining output register
    `F2DT_ASSERT(a_no_overwrite, i_clk, i_rst_n, cmd.emit |-> (!o_m_tvalid || i_m_tready), "output character overwritten")
    // after the final character the block is ready for the next item
    `F2DT_ASSERT(a_last_frees, i_clk, i_rst_n, (cmd.emit && cmd.last) |=> o_s_tready, "not ready after last character")
endmodule

>>> test/float_text_checker.sv
`timescale 1ns / 1ps

module float_text_checker #(
    parameter int FRACTION_DIGITS = f2dt_pkg::FRACTION_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,
    output int          o_fail_count,
    output int          o_chars_pending
);
    import f2dt_pkg::*;

    typedef struct {
        logic [6:0] code;
        logic       last;
        logic       err;
    } t_char;

    t_char char_queue[$];
    int    fail_count;

    assign o_fail_count    = fail_count;
    assign o_chars_pending = char_queue.size();

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) p = p * 64'd10;
        return p;
    endfunction

    function automatic int msb_of(input logic [63:0] v);
        int m;
        m = -1;
        for (int k = 0; k < 64; k++) if (v[k]) m = k;
        return m;
    endfunction

    // exact single-precision product, rounded to nearest even, then truncated
    function automatic void predict_text(input logic [31:0] bits);
        logic        sgn, err, neg;
        logic [7:0]  bexp;
        logic [22:0] frac;
        logic [63:0] prod, q, rem, half, mag, ipart, fpart, scale;
        int          ex, sh, lead, nd;
        logic [6:0]  digs[$];
        logic [6:0]  text[$];
        t_char       c;
        sgn   = bits[31];
        bexp  = bits[30:23];
        frac  = bits[22:0];
        scale = pow10(FRACTION_DIGITS);
        err   = 1'b0;
        mag   = '0;
        if (bexp == 8'hFF) begin
            err = 1'b1;
            if (frac != 0) mag = '0;
            else mag = sgn ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            if (bexp == 0) begin
                prod = 64'(frac) * scale;
                ex   = -149;
            end else begin
                prod = 64'({1'b1, frac}) * scale;
                ex   = int'(bexp) - 150;
            end
            lead = msb_of(prod);
            q    = prod;
            if (lead > 23) begin
                sh   = lead - 23;
                q    = prod >> sh;
                rem  = prod & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0])) q = q + 64'd1;
                if (q == (64'd1 << 24)) begin
                    q  = q >> 1;
                    sh = sh + 1;
                end
                ex = ex + sh;
            end
            if (ex >= 0) begin
                if (ex > 40 || (q << ex) > 64'h8000_0000_0000_0000 ||
                    ((q << ex) == 64'h8000_0000_0000_0000 && !sgn)) begin
                    err = 1'b1;
                    mag = sgn ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    mag = q << ex;
                end
            end else if (-ex >= 64) begin
                mag = '0;
            end else begin
                mag = q >> (-ex);
            end
        end
        neg   = sgn && (mag != 0) && !(bexp == 8'hFF && frac != 0);
        ipart = mag / scale;
        fpart = mag % scale;
        if (neg) text.push_back(CH_MINUS);
        do begin
            digs.push_front(CH_ZERO + 7'(ipart % 64'd10));
            ipart = ipart / 64'd10;
        end while (ipart != 0);
        nd = digs.size();
        for (int k = 0; k < nd; k++) text.push_back(digs[k]);
        text.push_back(CH_POINT);
        digs.delete();
        for (int k = 0; k < FRACTION_DIGITS; k++) begin
            digs.push_front(CH_ZERO + 7'(fpart % 64'd10));
            fpart = fpart / 64'd10;
        end
        for (int k = 0; k < FRACTION_DIGITS; k++) text.push_back(digs[k]);
        for (int k = 0; k < text.size(); k++) begin
            c.code = text[k];
            c.last = (k == text.size() - 1);
            c.err  = err;
            char_queue.push_back(c);
        end
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) predict_text(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (char_queue.size() == 0) begin
                    report($sformatf("unexpected char 0x%02h", i_m_tdata));
                end else begin
                    want = char_queue.pop_front();
                    if (i_m_tdata != {1'b0, want.code})
                        report($sformatf("char 0x%02h, expected 0x%02h",
                                         i_m_tdata, want.code));
                    if (i_m_tlast != want.last)
                        report($sformatf("tlast %0b, expected %0b", i_m_tlast, want.last));
                    if (i_m_tuser != want.err)
                        report($sformatf("range error %0b, expected %0b",
                                         i_m_tuser, want.err));
                end
            end
        end
    end
endmodule

>>> test/tb_float_to_decimal_text.sv
`timescale 1ns / 1ps

module tb_float_to_decimal_text;
    localparam int CYCLE_LIMIT = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] float_bits
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [6:0] char_code, [7] zero
    logic        m_tlast;    // last_char
    logic        m_tuser;    // range_error
    int          fail_count;
    int          chars_pending;
    int          cycle_count;
    int          hold_cycles;
    bit          quiet_mode;

    float_to_decimal_text DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    float_text_checker checker_0 (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .i_m_tuser       (m_tuser),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none during quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // output side: random stalls plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (cycle_count == 3000) begin
            hold_cycles <= 500;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= quiet_mode ? 1'b1 : ($urandom_range(0, 9) > 2);
        end
    end

    // offers one item, returns at the edge where it is taken
    task automatic send_value(input logic [31:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [31:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        // exponents around the interesting range: fractions through saturation
        if (r < 7) return {1'($urandom), 8'($urandom_range(100, 200)), 23'($urandom)};
        if (r < 8) return {1'($urandom), 8'($urandom_range(185, 192)), 23'($urandom)};
        return $urandom;
    endfunction

    logic [31:0] directed_values[] = '{
        32'h0000_0000,   // zero
        32'h8000_0000,   // negative zero
        32'h3F80_0000,   // 1.0
        32'hBF80_0000,   // -1.0
        32'hBF00_0000,   // -0.5
        32'h3D8F_9097,   // about 0.0701
        32'hB3D6_BF95,   // tiny negative, truncates to zero
        32'h3F7F_FFFF,   // just under 1
        32'h0000_0001,   // smallest subnormal
        32'h8000_0001,   // negative subnormal
        32'h007F_FFFF,   // largest subnormal
        32'h7FC0_0000,   // quiet nan
        32'hFFFF_FFFF,   // negative nan
        32'h7F80_0001,   // signaling nan
        32'h7F80_0000,   // +inf
        32'hFF80_0000,   // -inf
        32'h7F7F_FFFF,   // largest finite
        32'hFF7F_FFFF,   // most negative finite
        32'h5609_1C6F,   // past the positive saturation point
        32'hD609_1C6F,   // past the negative saturation point
        32'hD609_1C6E,
        32'h5609_1C70,
        32'h4B7F_FFFF,   // full-width integer digits
        32'h3400_0000,   // rounding edge of the scale multiply
        32'hCB00_0001
    };

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet_mode  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[k]) send_value(directed_values[k]);
        for (int k = 0; k < 400; k++) begin
            if (k % 50 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
            send_value(random_value());
        end
        s_tvalid <= 1'b0;
        quiet_mode = 1'b0;

        // let the checker record the last accepted item first
        @(posedge i_clk);
        while (chars_pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+src
src/f2dt_pkg.sv
src/f2dt_datapath.sv
src/f2dt_ctrl.sv
src/float_to_decimal_text.sv
test/float_text_checker.sv
test/tb_float_to_decimal_text.sv
